### hdl/box_downsample_2x2_quadrant_assert.svh
// Assertion macros shared by the downsampler modules.
`ifndef BOX_DOWNSAMPLE_2X2_QUADRANT_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_QUADRANT_ASSERT_SVH
`ifndef SYNTHESIS
`define BDSQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BDSQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> expr) else $error(msg);
`else
`define BDSQ_ASSERT(label, clk, rst, prop, msg)
`define BDSQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

### hdl/bdsq_pkg.sv
package bdsq_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_BPP     = 4;
  localparam int LINE_DEPTH  = (MAX_WIDTH / 2) * MAX_BPP;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);

  localparam int SAMPLE_W    = 8;
  localparam int PAIR_W      = SAMPLE_W + 1;
  localparam int COUNT_W     = 12;
  localparam int DIM_W       = 13;
  localparam int BPP_W       = 3;
  localparam int CHAN_W      = 2;
  localparam int QUAD_W      = 2;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUADRANT        = 2'd3;

  // What the back end does with one byte.
  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_PAIR,
    KIND_EMIT
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   chan;
    logic [LINE_AW-1:0]  lidx;
    logic [COUNT_W-1:0]  dest_col;
    logic [COUNT_W-1:0]  dest_row;
    logic                last;
  } cmd_t;

endpackage

### hdl/bdsq_if.sv
interface bdsq_in_if;
  import bdsq_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bdsq_out_if;
  import bdsq_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic [COUNT_W-1:0]  dest_col;
  logic [COUNT_W-1:0]  dest_row;
  logic [CHAN_W-1:0]   channel;
  logic                last_of_tile;
  modport source (output valid, output average, output dest_col, output dest_row,
                  output channel, output last_of_tile, input ready);
  modport sink (input valid, input average, input dest_col, input dest_row,
                input channel, input last_of_tile, output ready);
endinterface

### hdl/box_downsample_2x2_quadrant.sv
// 2x2 box downsampler with quadrant placement.
//
// source_bytes carries the source tile one channel byte per transfer, in
// raster order with the channels of each pixel interleaved. results carries
// one rounded 2x2 mean per channel of each block, with its destination
// column, row, channel and a flag on the last result of the tile. Results
// come only on the second row of each row pair, on the right pixel of a pair.
// The configuration port writes tile width, tile height, bytes per pixel and
// quadrant (indexes 0 to 3); write it only while no byte is in flight.
//
// One byte is taken per cycle while the queue is not full. A result is
// registered when the byte completing its block leaves the queue. Each byte
// passes once through the queue; a right byte writes its pair sum to the
// line store on an even row and reads it on an odd one, so the back end
// takes one byte per cycle unless a result is stalled. A four-entry queue
// keeps input flowing while a result waits; when the receiver stalls long
// enough the queue fills and source_bytes.ready drops. Reset clears the
// position counters and the queue and loads the register defaults
// (256 x 256, three bytes per pixel, top-left quadrant).
module box_downsample_2x2_quadrant (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bdsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdsq_pkg::CFG_W-1:0]     cfg_data,
  bdsq_in_if.sink                        source_bytes,
  bdsq_out_if.source                     results
);
  import bdsq_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  bdsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (source_bytes),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bdsq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  bdsq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res        (results)
  );

endmodule

### hdl/bdsq_ram.sv
module bdsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/bdsq_front.sv
module bdsq_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bdsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdsq_pkg::CFG_W-1:0]   cfg_data,
  bdsq_in_if.sink                      src,
  input  logic                         q_full,
  output logic                         push,
  output bdsq_pkg::cmd_t               push_cmd
);
  import bdsq_pkg::*;

  logic [DIM_W-1:0]   tile_width;
  logic [DIM_W-1:0]   tile_height;
  logic [BPP_W-1:0]   bytes_per_pixel;
  logic [QUAD_W-1:0]  quadrant;

  logic [COUNT_W-1:0] col_count;
  logic [COUNT_W-1:0] row_count;
  logic [CHAN_W-1:0]  chan_count;

  logic [DIM_W-1:0]   w_even, h_even, w_eff, h_eff;
  logic [BPP_W-1:0]   bpp_eff;
  logic               chan_wrap, col_wrap, row_wrap;
  logic [LINE_AW:0]   lidx_full;
  logic [COUNT_W-1:0] col_half, row_half, w_half, h_half;

  // Round the sizes down to even and clamp the size registers to the usable range.
  always_comb begin
    w_even = {tile_width[DIM_W-1:1], 1'b0};
    h_even = {tile_height[DIM_W-1:1], 1'b0};
    if (w_even < DIM_W'(2)) begin
      w_eff = DIM_W'(2);
    end else if (w_even > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = w_even;
    end
    if (h_even < DIM_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (h_even > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_even;
    end
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(MAX_BPP)) begin
      bpp_eff = BPP_W'(MAX_BPP);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign chan_wrap = (BPP_W'(chan_count) + BPP_W'(1)) >= bpp_eff;
  assign col_wrap  = (DIM_W'(col_count) + DIM_W'(1)) >= w_eff;
  assign row_wrap  = (DIM_W'(row_count) + DIM_W'(1)) >= h_eff;

  assign col_half  = {1'b0, col_count[COUNT_W-1:1]};
  assign row_half  = {1'b0, row_count[COUNT_W-1:1]};
  assign w_half    = w_eff[DIM_W-1:1];
  assign h_half    = h_eff[DIM_W-1:1];
  assign lidx_full = (LINE_AW+1)'(col_half) * (LINE_AW+1)'(bpp_eff)
                   + (LINE_AW+1)'(chan_count);

  assign src.ready = !q_full;
  assign push      = src.valid && !q_full;

  always_comb begin
    if (!col_count[0]) begin
      push_cmd.kind = KIND_HOLD;
    end else if (!row_count[0]) begin
      push_cmd.kind = KIND_PAIR;
    end else begin
      push_cmd.kind = KIND_EMIT;
    end
    push_cmd.sample   = src.sample;
    push_cmd.chan     = chan_count;
    push_cmd.lidx     = lidx_full[LINE_AW-1:0];
    push_cmd.dest_col = col_half + (quadrant[0] ? w_half : '0);
    push_cmd.dest_row = row_half + (quadrant[1] ? h_half : '0);
    push_cmd.last     = chan_wrap && col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width      <= DIM_W'(256);
      tile_height     <= DIM_W'(256);
      bytes_per_pixel <= BPP_W'(3);
      quadrant        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:      tile_width      <= cfg_data[DIM_W-1:0];
        REG_TILE_HEIGHT:     tile_height     <= cfg_data[DIM_W-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_QUADRANT:        quadrant        <= cfg_data[QUAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the raster position on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      chan_count <= '0;
    end else if (push) begin
      if (chan_wrap) begin
        chan_count <= '0;
        if (col_wrap) begin
          col_count <= '0;
          row_count <= row_wrap ? '0 : row_count + COUNT_W'(1);
        end else begin
          col_count <= col_count + COUNT_W'(1);
        end
      end else begin
        chan_count <= chan_count + CHAN_W'(1);
      end
    end
  end

endmodule

### hdl/bdsq_queue.sv
`include "box_downsample_2x2_quadrant_assert.svh"

module bdsq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bdsq_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output bdsq_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import bdsq_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head, tail;
  logic [QUEUE_AW:0]   count;

  assign full       = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QUEUE_AW'(1);
      end
      if (pop) begin
        head <= head + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  `BDSQ_ASSERT(a_no_overflow, clk, rst, !(push && full), "push into a full queue")
  `BDSQ_ASSERT(a_no_underflow, clk, rst, !(pop && !head_valid), "pop from an empty queue")
  `BDSQ_ASSERT(a_count_bound, clk, rst, count <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

### hdl/bdsq_back.sv
`include "box_downsample_2x2_quadrant_assert.svh"

module bdsq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  bdsq_pkg::cmd_t head_cmd,
  output logic           pop,
  bdsq_out_if.source     res
);
  import bdsq_pkg::*;

  logic [SAMPLE_W-1:0] left_byte_hold [MAX_BPP];
  logic [SAMPLE_W-1:0] left_byte;
  logic [PAIR_W-1:0]   pair_sum;
  logic [PAIR_W-1:0]   line_rd;
  logic                slot_free;
  logic                do_hold, do_pair, do_emit;

  logic                out_valid;
  logic [PAIR_W-1:0]   lower_pair;
  logic [COUNT_W-1:0]  out_col, out_row;
  logic [CHAN_W-1:0]   out_chan;
  logic                out_last;
  logic [PAIR_W:0]     block_sum;

  assign left_byte = left_byte_hold[head_cmd.chan];
  assign pair_sum  = PAIR_W'(left_byte) + PAIR_W'(head_cmd.sample);
  assign slot_free = !out_valid || res.ready;

  always_comb begin
    do_hold = 1'b0;
    do_pair = 1'b0;
    do_emit = 1'b0;
    unique case (head_cmd.kind)
      KIND_HOLD: do_hold = head_valid;
      KIND_PAIR: do_pair = head_valid;
      KIND_EMIT: do_emit = head_valid && slot_free;
      default: ;
    endcase
  end

  // Only a result-bearing byte waits for the output register.
  assign pop = do_hold || do_pair || do_emit;

  always_ff @(posedge clk) begin
    if (do_hold) begin
      left_byte_hold[head_cmd.chan] <= head_cmd.sample;
    end
  end

  bdsq_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (do_pair),
    .wr_addr (head_cmd.lidx),
    .wr_data (pair_sum),
    .rd_en   (do_emit),
    .rd_addr (head_cmd.lidx),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      lower_pair <= pair_sum;
      out_col    <= head_cmd.dest_col;
      out_row    <= head_cmd.dest_row;
      out_chan   <= head_cmd.chan;
      out_last   <= head_cmd.last;
    end
  end

  // Line data stays put until the next read, which only comes with a new result.
  assign block_sum        = (PAIR_W+1)'(line_rd) + (PAIR_W+1)'(lower_pair) + (PAIR_W+1)'(2);
  assign res.valid        = out_valid;
  assign res.average      = block_sum[PAIR_W:2];
  assign res.dest_col     = out_col;
  assign res.dest_row     = out_row;
  assign res.channel      = out_chan;
  assign res.last_of_tile = out_last;

  `BDSQ_ASSERT_NEXT(a_emit_shows, clk, rst, do_emit, out_valid, "issued result not presented")
  `BDSQ_ASSERT(a_no_overwrite, clk, rst, !(do_emit && out_valid && !res.ready), "stalled result overwritten")
  `BDSQ_ASSERT(a_one_action, clk, rst, $onehot0({do_hold, do_pair, do_emit}), "more than one action for a byte")

endmodule
